// ===== hdl/cdwc_pkg.sv =====
// ----------------------------------------------------------------------------
// cdwc_pkg
// Shared types and constants for the contactor dwell controller.
// ----------------------------------------------------------------------------
package cdwc_pkg;

  // request opcodes
  typedef enum logic [2:0] {
    OP_SET_PRE = 3'd0,
    OP_SET_DSG = 3'd1,
    OP_SET_CHG = 3'd2,
    OP_DISABLE = 3'd3,
    OP_REFRESH = 3'd4
  } cdwc_op_t;

  // configuration register indexes
  localparam logic [1:0] CFG_DWELL_TIME = 2'd0;
  localparam logic [1:0] CFG_FORCE_ON   = 2'd1;
  localparam logic [1:0] CFG_CHECK_EN   = 2'd2;
  localparam logic [1:0] CFG_PERCENT    = 2'd3;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // reset values
  localparam logic [15:0] DWELL_RESET   = 16'd3000;
  localparam logic [6:0]  PERCENT_RESET = 7'd90;
  localparam logic [7:0]  PATTERN_NONE  = 8'hFF;

  // drive pattern bit positions
  localparam int BIT_PRE = 0;
  localparam int BIT_DSG = 1;
  localparam int BIT_CHG = 2;

  // load * 100 for the readiness compare
  localparam logic [6:0] PCT_SCALE = 7'd100;

  // stream widths
  localparam int InDataW  = 72;
  localparam int InUserW  = 3;
  localparam int OutDataW = 8;

  // control into one dwell channel
  typedef struct packed {
    logic        sel;    // a set request for this channel is retiring
    logic        clear;  // disable-all is retiring
    logic        want;
    logic [31:0] now_ms;
  } chan_ctrl_t;

  // status out of one dwell channel
  typedef struct packed {
    logic change_ok;  // dwell elapsed and wanted state differs
  } chan_stat_t;

endpackage

// ===== hdl/cdwc_dwell_chan.sv =====
// ----------------------------------------------------------------------------
// cdwc_dwell_chan
// One contactor channel: last requested state, time of last change and the
// dwell check (modulo 2^32 time difference).
// ----------------------------------------------------------------------------
module cdwc_dwell_chan
  import cdwc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] dwell_time_ms,
  input  chan_ctrl_t  ctrl,
  output chan_stat_t  stat
);

  logic        last_r, last_nxt;
  logic [31:0] stamp_r, stamp_nxt;
  logic [31:0] elapsed;

  assign elapsed        = ctrl.now_ms - stamp_r;
  assign stat.change_ok = (elapsed >= {16'd0, dwell_time_ms}) && (last_r != ctrl.want);

  always_comb begin
    last_nxt  = last_r;
    stamp_nxt = stamp_r;
    if (ctrl.clear) begin
      last_nxt = 1'b0;
    end else if (ctrl.sel && stat.change_ok) begin
      last_nxt  = ctrl.want;
      stamp_nxt = ctrl.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= 1'b0;
      stamp_r <= 32'd0;
    end else begin
      last_r  <= last_nxt;
      stamp_r <= stamp_nxt;
    end
  end

endmodule

// ===== hdl/contactor_dwell_controller_top.sv =====
// ----------------------------------------------------------------------------
// contactor_dwell_controller_top
// Contactor controller for precharge, discharge and charge with per-channel
// dwell time, permission gating and precharge readiness check.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------
//  in_     | in  | tvalid/tready      | tuser opcode, tdata request fields
//  out_    | out | tvalid/tready      | tdata drive pattern, ready, changed
//  cfg_    | in  | wr_en (no wait)    | index 0..3, data 16 bit
//
//  One item per cycle sustained while out_tready is held high. An item is held
//  in the input register, is resolved by the update logic as it moves into the
//  result register, and is presented at out_ from the result register.
//  Contactor state updates only when an item moves into the result register,
//  so a stalled out_ side freezes that state and backs up to in_tready.
//  rst_n is synchronous: it empties both stages and restores register and
//  channel reset values.
//
module contactor_dwell_controller_top
  import cdwc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_tvalid,
  output logic                in_tready,
  // [0] wanted_state, [32:1] now_ms, [33] low_current_ok, [34] charge_ok,
  // [51:35] load_voltage_mv, [68:52] module_voltage_mv, [71:69] zero
  input  logic [InDataW-1:0]  in_tdata,
  // [2:0] opcode
  input  logic [InUserW-1:0]  in_tuser,

  output logic                out_tvalid,
  input  logic                out_tready,
  // [0] precharge_on, [1] discharge_on, [2] charge_on, [3] precharge_ready,
  // [4] drive_changed, [7:5] zero
  output logic [OutDataW-1:0] out_tdata,

  input  logic                cfg_wr_en,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  // ---------------- configuration registers ----------------
  logic [15:0] dwell_r;
  logic        force_on_r;
  logic        check_en_r;
  logic [6:0]  percent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_r    <= DWELL_RESET;
      force_on_r <= 1'b0;
      check_en_r <= 1'b0;
      percent_r  <= PERCENT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DWELL_TIME: dwell_r    <= cfg_data;
        CFG_FORCE_ON:   force_on_r <= cfg_data[0];
        CFG_CHECK_EN:   check_en_r <= cfg_data[0];
        CFG_PERCENT:    percent_r  <= cfg_data[6:0];
        default:        ;
      endcase
    end
  end

  // ---------------- input register ----------------
  logic                s1_valid_r;
  logic [InDataW-1:0]  s1_data_r;
  logic [InUserW-1:0]  s1_op_r;
  logic                s1_adv;   // stage-1 item moves to the result register
  logic                retire;

  assign s1_adv    = !out_tvalid || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign retire    = s1_valid_r && s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata;
      s1_op_r   <= in_tuser;
    end
  end

  // unpack the held item
  logic        want;
  logic [31:0] now_ms;
  logic        lc_ok, c_ok;
  logic [16:0] load_mv, module_mv;

  assign want      = s1_data_r[0];
  assign now_ms    = s1_data_r[32:1];
  assign lc_ok     = s1_data_r[33];
  assign c_ok      = s1_data_r[34];
  assign load_mv   = s1_data_r[51:35];
  assign module_mv = s1_data_r[68:52];

  logic is_pre, is_dsg, is_chg, is_dis, is_ref;
  assign is_pre = (s1_op_r == OP_SET_PRE);
  assign is_dsg = (s1_op_r == OP_SET_DSG);
  assign is_chg = (s1_op_r == OP_SET_CHG);
  assign is_dis = (s1_op_r == OP_DISABLE);
  assign is_ref = (s1_op_r == OP_REFRESH);

  // ---------------- dwell channels ----------------
  chan_ctrl_t ctrl_pre, ctrl_dsg, ctrl_chg;
  chan_stat_t stat_pre, stat_dsg, stat_chg;

  always_comb begin
    ctrl_pre = '{sel: retire && is_pre, clear: retire && is_dis, want: want, now_ms: now_ms};
    ctrl_dsg = '{sel: retire && is_dsg, clear: retire && is_dis, want: want, now_ms: now_ms};
    ctrl_chg = '{sel: retire && is_chg, clear: retire && is_dis, want: want, now_ms: now_ms};
  end

  cdwc_dwell_chan u_pre (.clk, .rst_n, .dwell_time_ms(dwell_r), .ctrl(ctrl_pre),
                         .stat(stat_pre));
  cdwc_dwell_chan u_dsg (.clk, .rst_n, .dwell_time_ms(dwell_r), .ctrl(ctrl_dsg),
                         .stat(stat_dsg));
  cdwc_dwell_chan u_chg (.clk, .rst_n, .dwell_time_ms(dwell_r), .ctrl(ctrl_chg),
                         .stat(stat_chg));

  // ---------------- drive update ----------------
  logic [2:0] desired_r, desired_nxt;
  logic [2:0] drive_r, drive_nxt;
  logic [7:0] last_rep_r, last_rep_nxt;
  logic [2:0] pattern;
  logic       set_taken;   // an accepted set request: recompute
  logic       changed;
  logic       dsg_perm;

  assign set_taken = (is_pre && stat_pre.change_ok) || (is_dsg && stat_dsg.change_ok) ||
                     (is_chg && stat_chg.change_ok);

  always_comb begin
    desired_nxt = desired_r;
    if (is_pre && stat_pre.change_ok) desired_nxt[BIT_PRE] = want;
    if (is_dsg && stat_dsg.change_ok) desired_nxt[BIT_DSG] = want;
    if (is_chg && stat_chg.change_ok) desired_nxt[BIT_CHG] = want;
  end

  assign dsg_perm         = lc_ok || force_on_r;
  assign pattern[BIT_PRE] = desired_nxt[BIT_PRE] && dsg_perm;
  assign pattern[BIT_DSG] = desired_nxt[BIT_DSG] && dsg_perm;
  assign pattern[BIT_CHG] = desired_nxt[BIT_CHG] && c_ok;

  always_comb begin
    drive_nxt    = drive_r;
    last_rep_nxt = last_rep_r;
    changed      = 1'b0;
    if (is_dis) begin
      drive_nxt = 3'b000;
    end else if (set_taken || is_ref) begin
      drive_nxt = pattern;
      if ({5'd0, pattern} != last_rep_r) begin
        changed      = 1'b1;
        last_rep_nxt = {5'd0, pattern};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desired_r  <= 3'b000;
      drive_r    <= 3'b000;
      last_rep_r <= PATTERN_NONE;
    end else if (retire) begin
      desired_r  <= desired_nxt;
      drive_r    <= drive_nxt;
      last_rep_r <= last_rep_nxt;
    end
  end

  // ---------------- readiness: load*100 < module*percent ----------------
  logic [23:0] load_scaled, module_scaled;
  logic        ready;

  assign load_scaled   = 24'(load_mv) * 24'(PCT_SCALE);
  assign module_scaled = 24'(module_mv) * 24'(percent_r);
  assign ready         = !(is_dsg && check_en_r && (load_scaled < module_scaled));

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (s1_adv) begin
      out_tvalid <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (retire) begin
      out_tdata <= {3'b000, changed, ready, drive_nxt};
    end
  end

endmodule

// ===== hdl/cdwc_checker.sv =====
// ----------------------------------------------------------------------------
// cdwc_checker
// Port-level checks for the contactor dwell controller, bound to the top.
// ----------------------------------------------------------------------------
module cdwc_checker
  import cdwc_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // input backs up only behind a full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with result register empty");

  // padding bits of a result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OutDataW-1:5] == '0))
    else $error("nonzero padding in result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind contactor_dwell_controller_top cdwc_checker u_cdwc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the contactor dwell controller. A scoreboard
// predicts one result per accepted request: dwell and change gating per
// channel, drive permission, readiness and change flag. It compares each
// result field by field, under random gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import cdwc_pkg::*;

  // Run-time guard. The slowest correct stretch with no handshake is the
  // receiver hold-off (HOLD_CYCLES) plus pipeline and gap delays.
  // The limit is many times that.
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 80;
  localparam int MAX_PRINTS  = 20;

  // opcodes the block treats as no-ops
  localparam logic [2:0] OP_NONE_FIRST = 3'd5;
  localparam logic [2:0] OP_NONE_LAST  = 3'd7;

  // out_tdata bits past the drive pattern
  localparam int OUT_READY   = 3;
  localparam int OUT_CHANGED = 4;

  localparam logic [16:0] MV_MAX = 17'h1FFFF;

  typedef struct {
    logic [2:0]  op;
    bit          want;
    bit [31:0]   now_ms;
    bit          lc_ok;
    bit          c_ok;
    bit [16:0]   load_mv;
    bit [16:0]   module_mv;
  } request_t;

  typedef struct {
    bit pre_on;
    bit dsg_on;
    bit chg_on;
    bit ready;
    bit changed;
  } drive_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the registers and the channel state
  // --------------------------------------------------------------------------
  class contactor_scoreboard;
    bit [15:0] dwell_ms;
    bit        force_on;
    bit        check_en;
    bit [6:0]  percent;

    bit [2:0]  last_req;       // per channel, same bit order as the drives
    bit [31:0] change_ms [3];
    bit [2:0]  desired;
    bit [2:0]  drive;
    bit [7:0]  reported;       // last reported pattern, all ones = none yet

    drive_result_t expected_drives[$];
    int errors, n_requests, n_results, n_changes, n_not_ready;

    function new();
      dwell_ms = DWELL_RESET;
      force_on = 1'b0;
      check_en = 1'b0;
      percent  = PERCENT_RESET;
      last_req = '0;
      foreach (change_ms[i]) change_ms[i] = '0;
      desired  = '0;
      drive    = '0;
      reported = PATTERN_NONE;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_DWELL_TIME: dwell_ms = val;
        CFG_FORCE_ON:   force_on = val[0];
        CFG_CHECK_EN:   check_en = val[0];
        CFG_PERCENT:    percent  = val[6:0];
        default: ;
      endcase
    endfunction

    // rebuild the drive pattern from the desired flags and live permissions
    function bit repattern(bit lc_ok, bit c_ok);
      bit [2:0] pat;
      bit       perm;
      perm = lc_ok | force_on;
      pat = '0;
      pat[BIT_PRE] = desired[BIT_PRE] & perm;
      pat[BIT_DSG] = desired[BIT_DSG] & perm;
      pat[BIT_CHG] = desired[BIT_CHG] & c_ok;
      drive = pat;
      if ({5'b0, pat} == reported) return 1'b0;
      reported = {5'b0, pat};
      return 1'b1;
    endfunction

    function bit try_channel(int ch, request_t r);
      bit [31:0] elapsed;
      elapsed = r.now_ms - change_ms[ch];   // wraps modulo 2^32
      if (elapsed < {16'b0, dwell_ms}) return 1'b0;
      if (last_req[ch] == r.want) return 1'b0;
      n_changes++;
      last_req[ch]  = r.want;
      desired[ch]   = r.want;
      change_ms[ch] = r.now_ms;
      return repattern(r.lc_ok, r.c_ok);
    endfunction

    function void note_request(request_t r);
      drive_result_t    res;
      longint unsigned  lhs, rhs;
      res.ready   = 1'b1;
      res.changed = 1'b0;
      case (r.op)
        OP_SET_PRE: res.changed = try_channel(BIT_PRE, r);
        OP_SET_DSG: begin
          res.changed = try_channel(BIT_DSG, r);
          lhs = 64'(r.load_mv) * 64'(PCT_SCALE);
          rhs = 64'(r.module_mv) * 64'(percent);
          if (check_en && lhs < rhs) begin
            res.ready = 1'b0;
            n_not_ready++;
          end
        end
        OP_SET_CHG: res.changed = try_channel(BIT_CHG, r);
        OP_DISABLE: begin
          // drives open, requests forgotten; desired flags stay
          drive    = '0;
          last_req = '0;
        end
        OP_REFRESH: res.changed = repattern(r.lc_ok, r.c_ok);
        default: ;
      endcase
      res.pre_on = drive[BIT_PRE];
      res.dsg_on = drive[BIT_DSG];
      res.chg_on = drive[BIT_CHG];
      expected_drives.push_back(res);
      n_requests++;
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTS)
        $display("MISMATCH result %0d: %s", n_results, msg);
      errors++;
    endtask

    task check_result(logic [OutDataW-1:0] data);
      drive_result_t exp_res;
      n_results++;
      if (expected_drives.size() == 0) begin
        report_mismatch($sformatf("no request pending, got %h", data));
        return;
      end
      exp_res = expected_drives.pop_front();
      if (data[BIT_PRE] !== exp_res.pre_on)
        report_mismatch($sformatf("precharge_on expected %b got %b",
                                  exp_res.pre_on, data[BIT_PRE]));
      if (data[BIT_DSG] !== exp_res.dsg_on)
        report_mismatch($sformatf("discharge_on expected %b got %b",
                                  exp_res.dsg_on, data[BIT_DSG]));
      if (data[BIT_CHG] !== exp_res.chg_on)
        report_mismatch($sformatf("charge_on expected %b got %b",
                                  exp_res.chg_on, data[BIT_CHG]));
      if (data[OUT_READY] !== exp_res.ready)
        report_mismatch($sformatf("precharge_ready expected %b got %b",
                                  exp_res.ready, data[OUT_READY]));
      if (data[OUT_CHANGED] !== exp_res.changed)
        report_mismatch($sformatf("drive_changed expected %b got %b",
                                  exp_res.changed, data[OUT_CHANGED]));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT and clock
  // --------------------------------------------------------------------------
  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic [InUserW-1:0]  in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_wr_en;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  contactor_dwell_controller_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  contactor_scoreboard sb;
  bit        gaps_on;        // random idle cycles on both sides
  bit        pressure_req;   // asks the result sink for one long hold-off
  bit [31:0] clock_ms;       // free-running time seen by the random requests

  // --------------------------------------------------------------------------
  // Driving tasks (inputs move on the falling edge)
  // --------------------------------------------------------------------------
  task automatic send_request(request_t r);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.op;
    in_tdata  <= {3'b0, r.module_mv, r.load_mv, r.c_ok, r.lc_ok, r.now_ms, r.want};
    do @(posedge clk); while (!in_tready);
    sb.note_request(r);
  endtask

  // stop offering and wait for every expected result
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_drives.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_register(idx, val);
  endtask

  task automatic write_all(bit [15:0] dwell, bit force_on, bit check_en, bit [6:0] pct);
    write_register(CFG_DWELL_TIME, dwell);
    write_register(CFG_FORCE_ON, {15'b0, force_on});
    write_register(CFG_CHECK_EN, {15'b0, check_en});
    write_register(CFG_PERCENT, {9'b0, pct});
  endtask

  function automatic request_t req(logic [2:0] op, bit want, bit [31:0] now_ms,
                                   bit lc_ok, bit c_ok, bit [16:0] load_mv,
                                   bit [16:0] module_mv);
    request_t r;
    r.op        = op;
    r.want      = want;
    r.now_ms    = now_ms;
    r.lc_ok     = lc_ok;
    r.c_ok      = c_ok;
    r.load_mv   = load_mv;
    r.module_mv = module_mv;
    return r;
  endfunction

  // Mostly set requests with time stepping around the dwell window, so that
  // about half pass the gate; some jumps and the odd bad opcode.
  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    bit [31:0]   level;
    pick = $urandom_range(99);
    if (pick < 60)      clock_ms += $urandom_range(2 * sb.dwell_ms + 2);
    else if (pick < 75) clock_ms += $urandom_range(15);
    else if (pick < 85) clock_ms = $urandom;
    r.now_ms = clock_ms;

    pick = $urandom_range(99);
    if (pick < 78)      r.op = 3'($urandom_range(OP_SET_CHG, OP_SET_PRE));
    else if (pick < 88) r.op = OP_REFRESH;
    else if (pick < 95) r.op = OP_DISABLE;
    else                r.op = 3'($urandom_range(OP_NONE_LAST, OP_NONE_FIRST));

    r.want      = 1'($urandom_range(1));
    r.lc_ok     = $urandom_range(99) < 80;
    r.c_ok      = $urandom_range(99) < 80;
    r.module_mv = 17'($urandom);
    if ($urandom_range(1)) begin
      // land near the readiness threshold
      level = 32'(r.module_mv) * 32'(sb.percent) / 32'(PCT_SCALE);
      level = level + $urandom_range(4);
      if (level >= 2) level -= 2;
      if (level > 32'(MV_MAX)) level = 32'(MV_MAX);
      r.load_mv = level[16:0];
    end else begin
      r.load_mv = 17'($urandom);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result sink: random ready, one long hold-off on request, check on rise
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_req) begin
        pressure_req = 1'b0;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        out_tready <= 1'b0;
        hold--;
      end else begin
        out_tready <= !(gaps_on && $urandom_range(99) < 10);
      end
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any handshake ends the run
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("tb_top NOT OK");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    gaps_on      = 1'b1;
    pressure_req = 1'b0;
    clock_ms     = '0;
    sb = new();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset settings: dwell 3000, no force, no readiness check.
    // First refresh reports the all-open pattern as a change.
    send_request(req(OP_REFRESH, 1'b0, 32'd0, 1'b1, 1'b1, 17'd0, 17'd0));
    // dwell not yet elapsed since reset time 0, then just short, then exact
    send_request(req(OP_SET_PRE, 1'b1, 32'd0, 1'b1, 1'b1, 17'd0, 17'd0));
    send_request(req(OP_SET_PRE, 1'b1, 32'd2999, 1'b1, 1'b1, 17'd0, 17'd0));
    send_request(req(OP_SET_PRE, 1'b1, 32'd3000, 1'b1, 1'b1, 17'd0, 17'd0));
    // same state again is no change
    send_request(req(OP_SET_PRE, 1'b1, 32'd9000, 1'b1, 1'b1, 17'd0, 17'd0));
    // discharge without low-current permission: both pre and dsg held open
    send_request(req(OP_SET_DSG, 1'b1, 32'd3000, 1'b0, 1'b1, 17'd0, MV_MAX));
    // charge wanted but not permitted, then a refresh that permits it
    send_request(req(OP_SET_CHG, 1'b1, 32'd3000, 1'b1, 1'b0, 17'd0, 17'd0));
    send_request(req(OP_REFRESH, 1'b0, 32'd3500, 1'b1, 1'b1, 17'd0, 17'd0));
    send_request(req(OP_REFRESH, 1'b0, 32'd3600, 1'b1, 1'b1, 17'd0, 17'd0));
    // disable all; the refresh after it closes again from the kept flags
    send_request(req(OP_DISABLE, 1'b0, 32'd4000, 1'b1, 1'b1, 17'd0, 17'd0));
    send_request(req(OP_REFRESH, 1'b0, 32'd4100, 1'b1, 1'b1, 17'd0, 17'd0));
    send_request(req(OP_DISABLE, 1'b1, 32'd4200, 1'b0, 1'b0, MV_MAX, MV_MAX));
    send_request(req(OP_SET_PRE, 1'b1, 32'd7000, 1'b1, 1'b1, 17'd0, 17'd0));
    send_request(req(OP_SET_CHG, 1'b0, 32'd6000, 1'b1, 1'b1, 17'd0, 17'd0));
    // time wrap: top of range, then exactly one dwell past the wrap
    send_request(req(OP_SET_CHG, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 17'd0, 17'd0));
    send_request(req(OP_SET_CHG, 1'b0, 32'd2999, 1'b1, 1'b1, 17'd0, 17'd0));
    // undefined opcodes
    for (int op = int'(OP_NONE_FIRST); op <= int'(OP_NONE_LAST); op++)
      send_request(req(3'(op), 1'b1, $urandom, 1'b1, 1'b1, 17'($urandom), 17'($urandom)));
    send_request(req(OP_SET_DSG, 1'b0, 32'd9000, 1'b1, 1'b1, MV_MAX, MV_MAX));

    // Directed, check on at 100 percent, dwell 0, force on
    drain_results();
    write_all(16'd0, 1'b1, 1'b1, 7'd100);
    send_request(req(OP_SET_DSG, 1'b0, 32'd0, 1'b1, 1'b1, 17'd100, 17'd100));
    send_request(req(OP_SET_DSG, 1'b1, 32'd0, 1'b0, 1'b1, 17'd99, 17'd100));
    send_request(req(OP_SET_PRE, 1'b1, 32'd0, 1'b0, 1'b0, 17'd0, 17'd0));
    send_request(req(OP_REFRESH, 1'b0, 32'd1, 1'b0, 1'b0, 17'd0, 17'd0));
    // percent above 100 is used as given; percent 0 always passes
    drain_results();
    write_register(CFG_PERCENT, 16'd127);
    send_request(req(OP_SET_DSG, 1'b0, 32'd2, 1'b1, 1'b1, MV_MAX, MV_MAX));
    drain_results();
    write_register(CFG_PERCENT, 16'd0);
    send_request(req(OP_SET_DSG, 1'b1, 32'd3, 1'b1, 1'b1, 17'd0, MV_MAX));

    // Random phases, each with its own register setting
    for (int ph = 0; ph < 5; ph++) begin
      drain_results();
      case (ph)
        0: begin
          write_all(16'd500, 1'b0, 1'b1, PERCENT_RESET);
          gaps_on = 1'b1;
          pressure_req = 1'b1;
        end
        1: begin
          // no idling anywhere in this phase
          write_all(16'd0, 1'b1, 1'b1, 7'd127);
          gaps_on = 1'b0;
        end
        2: begin
          write_all(16'hFFFF, 1'b0, 1'b0, 7'd0);
          gaps_on = 1'b1;
          clock_ms = 32'hFFF0_0000;   // runs across the wrap
        end
        3: begin
          write_all(16'($urandom_range(4000, 1)), 1'($urandom_range(1)), 1'b1,
                    7'($urandom_range(127)));
          pressure_req = 1'b1;
        end
        default: write_all(DWELL_RESET, 1'b1, 1'b1, PERCENT_RESET);
      endcase
      repeat (PHASE_ITEMS) send_request(random_request());
    end

    drain_results();
    repeat (4) @(posedge clk);   // catch any stray result past the last one

    $display("summary: %0d requests, %0d results, %0d channel changes, %0d not ready",
             sb.n_requests, sb.n_results, sb.n_changes, sb.n_not_ready);
    $display("summary: dwell 0 to 65535, time wrap, force-on, percent 0 to 127, %0d errors",
             sb.errors);
    if (sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
